FILE: design/dcc_pkg.sv
// shared types and constants of the draw command clipper
// payload structs, operation and depth codes, register indexes and reset values
// no dependencies
package dcc_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int BPL_W      = 13;
  localparam int OFFSET_W   = 30;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    OP_PIXEL  = 3'd0,
    OP_HLINE  = 3'd1,
    OP_VLINE  = 3'd2,
    OP_RECT   = 3'd3,
    OP_BITMAP = 3'd4
  } dcc_op_t;

  localparam logic [2:0] BPP_1  = 3'd0;
  localparam logic [2:0] BPP_2  = 3'd1;
  localparam logic [2:0] BPP_4  = 3'd2;
  localparam logic [2:0] BPP_8  = 3'd3;
  localparam logic [2:0] BPP_16 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 4'd3;

  localparam logic signed [COORD_W-1:0] CLIP_LEFT_RST   = '0;
  localparam logic signed [COORD_W-1:0] CLIP_TOP_RST    = '0;
  localparam logic signed [COORD_W-1:0] CLIP_RIGHT_RST  = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] CLIP_BOTTOM_RST = COORD_W'(SCREEN_HEIGHT - 1);

  typedef struct packed {
    logic [2:0]                 operation;
    logic signed [COORD_W-1:0]  x_start;
    logic signed [COORD_W-1:0]  y_start;
    logic signed [COORD_W-1:0]  x_end;
    logic signed [COORD_W-1:0]  y_end;
    logic [SIZE_W-1:0]          width;
    logic [SIZE_W-1:0]          height;
    logic [2:0]                 bpp_code;
    logic [BPL_W-1:0]           bytes_per_line;
  } dcc_cmd_t;

  typedef struct packed {
    logic [2:0]                 out_operation;
    logic signed [COORD_W-1:0]  out_x_start;
    logic signed [COORD_W-1:0]  out_y_start;
    logic signed [COORD_W-1:0]  out_x_end;
    logic signed [COORD_W-1:0]  out_y_end;
    logic [SIZE_W-1:0]          out_width;
    logic [SIZE_W-1:0]          out_height;
    logic [OFFSET_W-1:0]        byte_offset;
    logic [2:0]                 bit_skip;
  } dcc_res_t;

endpackage

FILE: design/dcc_ifs.sv
// valid/ready channels of the draw command clipper: commands, results, register writes
// depends on dcc_pkg
interface dcc_cmd_if import dcc_pkg::*; ();
  logic     valid;
  logic     ready;
  dcc_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcc_res_if import dcc_pkg::*; ();
  logic     valid;
  logic     ready;
  dcc_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcc_cfg_if import dcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/draw_command_clipper.sv
// Clip stage for a 2D drawing engine. It takes one draw command per clock,
// unless res.ready stalls it, and returns it clipped to the rectangle held in
// four registers, or drops it when nothing is visible or its op or bpp is invalid.
// Edge detect, bitmap offset multiply, and size and offset sums each take one
// register stage, the last holds the result; dropped commands leave a bubble.
// Register writes are taken at any time but are only meaningful while empty.
// depends on dcc_pkg and dcc_ifs
module draw_command_clipper import dcc_pkg::*; (
  input logic    clk,
  input logic    rst,
  dcc_cmd_if.sink   cmd,
  dcc_res_if.source res,
  dcc_cfg_if.sink   cfg
);

  typedef struct packed {
    logic [2:0]                op;
    logic                      keep;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xs_c;
    logic signed [COORD_W-1:0] ys_c;
    logic signed [COORD_W-1:0] xe_c;
    logic signed [COORD_W-1:0] ye_c;
    logic                      x_in;
    logic                      y_in;
    logic signed [17:0]        x1;
    logic signed [17:0]        y1;
    logic signed [16:0]        dtop;
    logic signed [16:0]        dleft;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [2:0]                bpp;
    logic [BPL_W-1:0]          bpl;
  } s1_t;

  typedef struct packed {
    logic [2:0]                op;
    logic                      keep;
    logic                      is_bm;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [15:0]               dtop_p;
    logic [15:0]               dleft_p;
    logic [16:0]               dright_p;
    logic [16:0]               dbot_p;
    logic [28:0]               prod;
    logic [16:0]               part;
    logic [2:0]                skip;
  } s2_t;

  logic signed [COORD_W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  logic     s1_v, s2_v, out_v;
  s1_t      s1, s1_next;
  s2_t      s2, s2_next;
  dcc_res_t out_r, out_next;
  logic     out_keep;
  logic     en1, en2, en3;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= CLIP_LEFT_RST;
      clip_top    <= CLIP_TOP_RST;
      clip_right  <= CLIP_RIGHT_RST;
      clip_bottom <= CLIP_BOTTOM_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CLIP_LEFT:   clip_left   <= $signed(cfg.data);
        CFG_CLIP_TOP:    clip_top    <= $signed(cfg.data);
        CFG_CLIP_RIGHT:  clip_right  <= $signed(cfg.data);
        CFG_CLIP_BOTTOM: clip_bottom <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign en3       = !out_v || res.ready;
  assign en2       = !s2_v || en3;
  assign en1       = !s1_v || en2;
  assign cmd.ready = en1;

  // stage 1: edge compares and clamps
  always_comb begin
    logic signed [COORD_W-1:0] xs, ys, xe, ye;
    xs = $signed(cmd.data.x_start);
    ys = $signed(cmd.data.y_start);
    xe = $signed(cmd.data.x_end);
    ye = $signed(cmd.data.y_end);
    s1_next.op    = cmd.data.operation;
    s1_next.keep  = (cmd.data.operation inside {[OP_PIXEL:OP_BITMAP]}) &&
                    (cmd.data.operation != OP_BITMAP ||
                     cmd.data.bpp_code inside {[BPP_1:BPP_16]});
    s1_next.xs    = xs;
    s1_next.ys    = ys;
    s1_next.xs_c  = (xs < clip_left)   ? clip_left   : xs;
    s1_next.ys_c  = (ys < clip_top)    ? clip_top    : ys;
    s1_next.xe_c  = (xe > clip_right)  ? clip_right  : xe;
    s1_next.ye_c  = (ye > clip_bottom) ? clip_bottom : ye;
    s1_next.x_in  = !(xs < clip_left) && !(xs > clip_right);
    s1_next.y_in  = !(ys < clip_top) && !(ys > clip_bottom);
    s1_next.x1    = $signed({{2{xs[15]}}, xs}) + $signed({3'b000, cmd.data.width})
                    - 18'sd1;
    s1_next.y1    = $signed({{2{ys[15]}}, ys}) + $signed({3'b000, cmd.data.height})
                    - 18'sd1;
    s1_next.dtop  = $signed({clip_top[15], clip_top}) - $signed({ys[15], ys});
    s1_next.dleft = $signed({clip_left[15], clip_left}) - $signed({xs[15], xs});
    s1_next.w     = cmd.data.width;
    s1_next.h     = cmd.data.height;
    s1_next.bpp   = cmd.data.bpp_code;
    s1_next.bpl   = cmd.data.bytes_per_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && cmd.valid) begin
      s1 <= s1_next;
    end
  end

  // stage 2: line decisions, bitmap overhangs, row offset multiply
  always_comb begin
    logic signed [17:0]        dright, dbot;
    logic                      x_ok, y_ok;
    logic [15:0]               align;
    logic signed [COORD_W-1:0] xs_bm;
    dright = s1.x1 - $signed({{2{clip_right[15]}}, clip_right});
    dbot   = s1.y1 - $signed({{2{clip_bottom[15]}}, clip_bottom});
    x_ok   = !($signed(s1.xe_c) < $signed(s1.xs_c));
    y_ok   = !($signed(s1.ye_c) < $signed(s1.ys_c));

    s2_next.op       = s1.op;
    s2_next.is_bm    = (s1.op == OP_BITMAP);
    s2_next.w        = s1.w;
    s2_next.h        = s1.h;
    s2_next.dtop_p   = (s1.dtop > 17'sd0) ? s1.dtop[15:0] : 16'd0;
    s2_next.dleft_p  = (s1.dleft > 17'sd0) ? s1.dleft[15:0] : 16'd0;
    s2_next.dright_p = (dright > 18'sd0) ? dright[16:0] : 17'd0;
    s2_next.dbot_p   = (dbot > 18'sd0) ? dbot[16:0] : 17'd0;
    s2_next.prod     = {13'd0, s2_next.dtop_p} * {16'd0, s1.bpl};

    case (s1.bpp)
      BPP_1: begin
        s2_next.part = {4'd0, s2_next.dleft_p[15:3]};
        align        = {s2_next.dleft_p[15:3], 3'd0};
        s2_next.skip = s2_next.dleft_p[2:0];
      end
      BPP_2: begin
        s2_next.part = {3'd0, s2_next.dleft_p[15:2]};
        align        = {s2_next.dleft_p[15:2], 2'd0};
        s2_next.skip = {1'b0, s2_next.dleft_p[1:0]};
      end
      BPP_4: begin
        s2_next.part = {2'd0, s2_next.dleft_p[15:1]};
        align        = {s2_next.dleft_p[15:1], 1'b0};
        s2_next.skip = {2'd0, s2_next.dleft_p[0]};
      end
      BPP_8: begin
        s2_next.part = {1'b0, s2_next.dleft_p};
        align        = s2_next.dleft_p;
        s2_next.skip = 3'd0;
      end
      default: begin
        s2_next.part = {s2_next.dleft_p, 1'b0};
        align        = s2_next.dleft_p;
        s2_next.skip = 3'd0;
      end
    endcase
    xs_bm = s1.xs + $signed(align);

    s2_next.xs   = s1.xs;
    s2_next.ys   = s1.ys;
    s2_next.xe   = '0;
    s2_next.ye   = '0;
    s2_next.keep = s1.keep;
    case (s1.op)
      OP_PIXEL: begin
        s2_next.keep = s1.keep && s1.x_in && s1.y_in;
      end
      OP_HLINE: begin
        s2_next.xs   = s1.xs_c;
        s2_next.xe   = s1.xe_c;
        s2_next.ye   = s1.ys;
        s2_next.keep = s1.keep && s1.y_in && x_ok;
      end
      OP_VLINE: begin
        s2_next.ys   = s1.ys_c;
        s2_next.xe   = s1.xs;
        s2_next.ye   = s1.ye_c;
        s2_next.keep = s1.keep && s1.x_in && y_ok;
      end
      OP_RECT: begin
        s2_next.xs   = s1.xs_c;
        s2_next.ys   = s1.ys_c;
        s2_next.xe   = s1.xe_c;
        s2_next.ye   = s1.ye_c;
        s2_next.keep = s1.keep && x_ok && y_ok;
      end
      OP_BITMAP: begin
        s2_next.xs = xs_bm;
        s2_next.ys = s1.ys_c;
      end
      default: begin
        s2_next.keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v && s1.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v) begin
      s2 <= s2_next;
    end
  end

  // stage 3: clipped size and source offset
  always_comb begin
    logic signed [18:0] w_fin, h_fin;
    w_fin = $signed({4'd0, s2.w}) - $signed({3'd0, s2.dleft_p})
            - $signed({2'd0, s2.dright_p});
    h_fin = $signed({4'd0, s2.h}) - $signed({3'd0, s2.dtop_p})
            - $signed({2'd0, s2.dbot_p});
    out_keep = s2.keep && (!s2.is_bm || (w_fin > 19'sd0 && h_fin > 19'sd0));

    out_next.out_operation = s2.op;
    out_next.out_x_start   = s2.xs;
    out_next.out_y_start   = s2.ys;
    out_next.out_x_end     = s2.xe;
    out_next.out_y_end     = s2.ye;
    out_next.out_width     = s2.is_bm ? w_fin[SIZE_W-1:0] : '0;
    out_next.out_height    = s2.is_bm ? h_fin[SIZE_W-1:0] : '0;
    out_next.byte_offset   = s2.is_bm ? ({1'b0, s2.prod} + {13'd0, s2.part}) : '0;
    out_next.bit_skip      = s2.is_bm ? s2.skip : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en3) begin
      out_v <= s2_v && out_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_v) begin
      out_r <= out_next;
    end
  end

  assign res.valid = out_v;
  assign res.data  = out_r;

  // checks
  a_bitmap_nonempty: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.out_operation == OP_BITMAP) |->
      (res.data.out_width != '0 && res.data.out_height != '0))
    else $error("bitmap result with empty size");

  a_offset_bitmap_only: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.out_operation != OP_BITMAP) |->
      (res.data.byte_offset == '0 && res.data.bit_skip == 3'd0 &&
       res.data.out_width == '0))
    else $error("bitmap fields set on a non-bitmap result");

  a_hline_order: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.out_operation == OP_HLINE) |->
      (res.data.out_y_end == res.data.out_y_start &&
       !($signed(res.data.out_x_end) < $signed(res.data.out_x_start))))
    else $error("horizontal line result out of order");

  a_bad_op_dropped: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.data.operation > OP_BITMAP) |=> !s1.keep)
    else $error("unknown operation not marked for drop");

  a_stall_holds_stage2: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !en3) |=> (s2_v && $stable(s2)))
    else $error("middle stage changed while stalled");

endmodule
